@@ rtl/sto_pkg.sv @@
package sto_pkg;

  localparam int TIME_W  = 32;
  localparam int TOTAL_W = 13;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 13'd8191;

  localparam int DEF_ENTRIES       = 32;
  localparam int DEF_MAX_CALLBACKS = 255;

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIRE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NEXT   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_TBL_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_CNT_FULL = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] ta;
    logic [TIME_W-1:0] tb;
  } query_t;

  // commit command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic inc;
  } cell_cmd_t;

  // handed from each cell to the next one up
  typedef struct packed {
    logic ge;   // cell sits at or above the insertion point
    logic gt;   // occupied and later than the query time
  } link_t;

  typedef struct packed {
    logic eq_hit;
    logic full_hit;
  } cell_stat_t;

  typedef struct packed {
    logic               hit;
    logic [TIME_W-1:0]  tm;
    logic [TOTAL_W-1:0] total;
  } leaf_t;

  function automatic leaf_t leaf_merge(leaf_t a, leaf_t b);
    logic [TOTAL_W:0] s;
    leaf_t r;
    s = {1'b0, a.total} + {1'b0, b.total};
    r.hit = a.hit | b.hit;
    r.tm  = a.tm | b.tm;
    r.total = (s > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : s[TOTAL_W-1:0];
    return r;
  endfunction

endpackage

@@ rtl/sorted_timeout_table.sv @@
// Sequence: an add passes from the compare state to the evaluate state and then to
// done; fire, next and lookup wait after evaluate on the registered summing tree.
// A new transaction is taken only in the idle state and done holds until the output
// register is free, so the cell chain handles one transaction at a time.
// Reset: rst_n (synchronous, active low) empties the table and clears the
// sequencer and output valid; cell contents are undefined until written.
module sorted_timeout_table import sto_pkg::*; #(
  parameter int ENTRIES       = DEF_ENTRIES,
  parameter int MAX_CALLBACKS = DEF_MAX_CALLBACKS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [TIME_W-1:0]  in_time_a,
  input  logic [TIME_W-1:0]  in_time_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  out_status,
  output logic               out_found,
  output logic [TIME_W-1:0]  out_time_value,
  output logic [TOTAL_W-1:0] out_callback_total
);

  localparam int CNT_W  = $clog2(MAX_CALLBACKS + 1);
  localparam int USED_W = $clog2(ENTRIES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  query_t query_r;
  logic [USED_W-1:0] used_r, used_nxt;

  logic [STAT_W-1:0]  res_status_r, res_status_nxt;
  logic               res_found_r, res_found_nxt;
  logic [TIME_W-1:0]  res_tm_r, res_tm_nxt;
  logic [TOTAL_W-1:0] res_total_r, res_total_nxt;

  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic               out_found_r;
  logic [TIME_W-1:0]  out_tm_r;
  logic [TOTAL_W-1:0] out_total_r;

  cell_cmd_t cmd;
  logic cap, tree_start, tree_done;
  leaf_t tree_root;

  link_t             links   [ENTRIES];
  logic [TIME_W-1:0] tm_link [ENTRIES];
  logic [CNT_W-1:0]  cnt_link[ENTRIES];
  cell_stat_t        stats   [ENTRIES];
  leaf_t             leaves  [ENTRIES];
  logic [ENTRIES-1:0] eq_hits, full_hits;
  logic any_eq, any_full;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      link_t             lp;
      logic [TIME_W-1:0] tp;
      logic [CNT_W-1:0]  cp;
      if (g == 0) begin : g_first
        assign lp = '0;
        assign tp = '0;
        assign cp = '0;
      end else begin : g_rest
        assign lp = links[g-1];
        assign tp = tm_link[g-1];
        assign cp = cnt_link[g-1];
      end
      sto_cell #(
        .IDX    (g),
        .CNT_W  (CNT_W),
        .USED_W (USED_W),
        .MAX_CB (MAX_CALLBACKS)
      ) u_cell (
        .clk       (clk),
        .query     (query_r),
        .cap       (cap),
        .cmd       (cmd),
        .used      (used_r),
        .link_prev (lp),
        .tm_prev   (tp),
        .cnt_prev  (cp),
        .link_out  (links[g]),
        .tm_out    (tm_link[g]),
        .cnt_out   (cnt_link[g]),
        .stat      (stats[g]),
        .leaf      (leaves[g])
      );
      assign eq_hits[g]   = stats[g].eq_hit;
      assign full_hits[g] = stats[g].full_hit;
    end
  endgenerate

  assign any_eq   = |eq_hits;
  assign any_full = |full_hits;

  sto_sum_tree #(
    .N (ENTRIES)
  ) u_tree (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (tree_start),
    .leaves (leaves),
    .done   (tree_done),
    .root   (tree_root)
  );

  assign in_ready   = state_r == ST_IDLE;
  assign cap        = state_r == ST_CMP;
  assign tree_start = (state_r == ST_EVAL) && (query_r.mode != MODE_ADD);

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    cmd            = '0;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_tm_nxt     = res_tm_r;
    res_total_nxt  = res_total_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (query_r.mode == MODE_ADD) begin
          res_status_nxt = STAT_OK;
          res_found_nxt  = 1'b0;
          res_tm_nxt     = '0;
          res_total_nxt  = '0;
          priority if (any_eq && any_full) begin
            res_status_nxt = STAT_CNT_FULL;
          end else if (any_eq) begin
            cmd.inc = 1'b1;
          end else if (used_r == USED_W'(ENTRIES)) begin
            res_status_nxt = STAT_TBL_FULL;
          end else begin
            cmd.ins  = 1'b1;
            used_nxt = used_r + USED_W'(1);
          end
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (tree_done) begin
          res_status_nxt = STAT_OK;
          res_found_nxt  = tree_root.hit;
          res_tm_nxt     = tree_root.tm;
          res_total_nxt  = tree_root.total;
          state_nxt      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      query_r.mode <= in_mode;
      query_r.ta   <= in_time_a;
      query_r.tb   <= in_time_b;
    end
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_tm_r     <= res_tm_nxt;
    res_total_r  <= res_total_nxt;
    if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_tm_r     <= res_tm_r;
      out_total_r  <= res_total_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found          = out_found_r;
  assign out_time_value     = out_tm_r;
  assign out_callback_total = out_total_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(ENTRIES))
    else $error("entry count above table size");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EVAL |-> $onehot0(eq_hits))
    else $error("more than one cell matches the query time");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    used_r != $past(used_r) |-> used_r == $past(used_r) + USED_W'(1))
    else $error("entry count moved by more than one insert");

  a_tree_timing: assert property (@(posedge clk) disable iff (!rst_n)
    tree_done |-> state_r == ST_WAIT)
    else $error("tree result outside wait state");

endmodule

@@ rtl/sto_cell.sv @@
module sto_cell import sto_pkg::*; #(
  parameter int IDX    = 0,
  parameter int CNT_W  = 8,
  parameter int USED_W = 6,
  parameter int MAX_CB = DEF_MAX_CALLBACKS
) (
  input  logic              clk,
  input  query_t            query,
  input  logic              cap,
  input  cell_cmd_t         cmd,
  input  logic [USED_W-1:0] used,
  input  link_t             link_prev,
  input  logic [TIME_W-1:0] tm_prev,
  input  logic [CNT_W-1:0]  cnt_prev,
  output link_t             link_out,
  output logic [TIME_W-1:0] tm_out,
  output logic [CNT_W-1:0]  cnt_out,
  output cell_stat_t        stat,
  output leaf_t             leaf
);

  localparam int EXT_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

  logic [TIME_W-1:0] tm_r;
  logic [CNT_W-1:0]  cnt_r;
  logic lt_r, eq_r, gt_r, rng_r, max_r;
  logic occ, ge, first_gt, eq_occ;
  logic [EXT_W-1:0]   cnt_ext;
  logic [TOTAL_W-1:0] cnt_sat;

  assign occ      = USED_W'(IDX) < used;
  assign ge       = !(occ && lt_r);
  assign eq_occ   = occ && eq_r;
  assign first_gt = occ && gt_r && !link_prev.gt;

  assign link_out.ge = ge;
  assign link_out.gt = occ && gt_r;
  assign tm_out      = tm_r;
  assign cnt_out     = cnt_r;

  assign stat.eq_hit   = eq_occ;
  assign stat.full_hit = eq_occ && max_r;

  assign cnt_ext = EXT_W'(cnt_r);
  assign cnt_sat = (cnt_ext > EXT_W'(TOTAL_MAX)) ? TOTAL_MAX : cnt_ext[TOTAL_W-1:0];

  always_comb begin
    leaf = '0;
    unique case (query.mode)
      MODE_FIRE: begin
        if (occ && rng_r) leaf.total = cnt_sat;
      end
      MODE_NEXT: begin
        leaf.hit = first_gt;
        if (first_gt) leaf.tm = tm_r;
      end
      MODE_LOOKUP: begin
        leaf.hit = eq_occ;
        if (eq_occ) leaf.total = cnt_sat;
      end
      default: begin
        leaf = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      lt_r  <= tm_r < query.ta;
      eq_r  <= tm_r == query.ta;
      gt_r  <= tm_r > query.ta;
      rng_r <= (tm_r != '0) && (tm_r > query.ta) && (tm_r <= query.tb);
      max_r <= cnt_r == CNT_W'(MAX_CB);
    end
    if (cmd.ins) begin
      if (ge && !link_prev.ge) begin
        tm_r  <= query.ta;
        cnt_r <= CNT_W'(1);
      end else if (link_prev.ge) begin
        tm_r  <= tm_prev;
        cnt_r <= cnt_prev;
      end
    end else if (cmd.inc && eq_occ) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

endmodule

@@ rtl/sto_sum_tree.sv @@
module sto_sum_tree import sto_pkg::*; #(
  parameter int N = DEF_ENTRIES
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  leaf_t leaves [N],
  output logic  done,
  output leaf_t root
);

  localparam int LEVELS = (N > 1) ? $clog2(N) : 1;
  localparam int P      = 1 << LEVELS;

  leaf_t leaf_pad [P];
  leaf_t node_r [1:P-1];
  logic [LEVELS-1:0] vld_r;

  genvar j, i;
  generate
    for (j = 0; j < P; j++) begin : g_pad
      if (j < N) begin : g_real
        assign leaf_pad[j] = leaves[j];
      end else begin : g_zero
        assign leaf_pad[j] = '0;
      end
    end
    for (i = 1; i < P; i++) begin : g_node
      if (2 * i >= P) begin : g_bottom
        always_ff @(posedge clk) begin
          node_r[i] <= leaf_merge(leaf_pad[2*i-P], leaf_pad[2*i+1-P]);
        end
      end else begin : g_inner
        always_ff @(posedge clk) begin
          node_r[i] <= leaf_merge(node_r[2*i], node_r[2*i+1]);
        end
      end
    end
  endgenerate

  // one valid bit per tree level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= LEVELS'({vld_r, start});
    end
  end

  assign done = vld_r[LEVELS-1];
  assign root = node_r[1];

endmodule
